FILE: src/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants for the planar point transform
// Widths, fixed-point formats, operation codes, sequencer states and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 8;

  localparam int FUNC_W  = 3;
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int AREA_W  = 48;

  localparam int ATAN_N    = 24;
  localparam int STEPS_EFF = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
  localparam int STEP_W    = $clog2(ATAN_N);

  localparam int DIFF_W = COORD_W + 1;
  localparam int ROT_W  = DIFF_W + GUARD_BITS + 3;
  localparam int PROD_W = 2 * COORD_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SAT_W  = PROD_W + 2;

  localparam logic [COORD_W-1:0] INV_GAIN = 32'h9B74EDA8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [ROT_W-1:0]   rot_t;
  typedef logic signed [SAT_W-1:0]   sat_t;
  typedef logic        [PROD_W-1:0]  prod_t;
  typedef logic        [ACC_W-1:0]   acc_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_CENTER = 3'd0,
    FN_LOAD_VERTEX = 3'd1,
    FN_LOAD_FOCUS  = 3'd2,
    FN_TRANSLATE   = 3'd3,
    FN_SCALE       = 3'd4,
    FN_ROTATE      = 3'd5
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_DIFF,
    ST_SC_MUL,
    ST_SC_WB,
    ST_RT_LOAD,
    ST_RT_ITER,
    ST_RT_MLO,
    ST_RT_MHI,
    ST_RT_WB,
    ST_AR_DIFF,
    ST_AR_MUL,
    ST_AR_ACC,
    ST_OUT
  } state_t;

  function automatic logic [COORD_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [COORD_W-1:0] r;
    unique case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051D;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2E;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A2F;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028B;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000A2;
      5'd23:   r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamps a wide signed value to the signed coordinate range.
  function automatic coord_t sat_coord(input sat_t v);
    logic [SAT_W-COORD_W:0] hi;
    coord_t r;
    hi = v[SAT_W-1:COORD_W-1];
    if ((&hi) || !(|hi)) begin
      r = v[COORD_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: src/ppt_if.sv
// ----------------------------------------------------------------------------
// ppt_cmd_if / ppt_res_if: command and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface ppt_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [ppt_pkg::FUNC_W-1:0]        func;
  logic signed [ppt_pkg::COORD_W-1:0] coord_x;
  logic signed [ppt_pkg::COORD_W-1:0] coord_y;
  logic signed [ppt_pkg::COORD_W-1:0] scale_factor;
  logic [ppt_pkg::ANGLE_W-1:0]       turn_angle;

  modport source(output valid, func, coord_x, coord_y, scale_factor, turn_angle,
                 input ready);
  modport sink(input valid, func, coord_x, coord_y, scale_factor, turn_angle,
               output ready);
endinterface

interface ppt_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [ppt_pkg::COORD_W-1:0] center_x_out;
  logic signed [ppt_pkg::COORD_W-1:0] center_y_out;
  logic signed [ppt_pkg::COORD_W-1:0] vertex_x_out;
  logic signed [ppt_pkg::COORD_W-1:0] vertex_y_out;
  logic signed [ppt_pkg::COORD_W-1:0] focus_x_out;
  logic signed [ppt_pkg::COORD_W-1:0] focus_y_out;
  logic [ppt_pkg::AREA_W-1:0]         square_area;

  modport source(output valid, center_x_out, center_y_out, vertex_x_out,
                 vertex_y_out, focus_x_out, focus_y_out, square_area,
                 input ready);
  modport sink(input valid, center_x_out, center_y_out, vertex_x_out,
               vertex_y_out, focus_x_out, focus_y_out, square_area,
               output ready);
endinterface

FILE: src/planar_point_transform.sv
// ----------------------------------------------------------------------------
// planar_point_transform: rotate, scale and translate of three Q16.16 points
// Holds a center, a vertex and a focus and applies one operation per command.
// ----------------------------------------------------------------------------
// One command is taken at a time; every command returns one result with all
// six coordinates and the saturated square area of the vertex offset. After
// the command transfer, a load, a translate or an unused code goes through
// the area states and the output state before the block is ready again; a
// scale first scales each point axis, and a rotation first runs CORDIC and
// gain removal on each point. The single 32x32 multiplier serves scaling,
// gain removal and squaring in turn, and the CORDIC stage does one
// iteration per cycle. A result still waiting in the output register when
// the next one is complete holds the sequencer in its output state, and so
// holds off the next command, until that result is transferred.
module planar_point_transform (
  input  logic        clk,
  input  logic        rst,
  ppt_cmd_if.sink     cmd,
  ppt_res_if.source   res
);

  ppt_pkg::state_t state, state_next;

  ppt_pkg::coord_t center_x, center_y, vertex_x, vertex_y, focus_x, focus_y;

  logic                            pt_sel;
  logic                            axis;
  logic [ppt_pkg::STEP_W-1:0]      step;
  logic [ppt_pkg::COORD_W-1:0]     dmag;
  logic                            dneg;
  ppt_pkg::prod_t                  prod;
  ppt_pkg::acc_t                   acc;
  ppt_pkg::rot_t                   rx, ry;
  ppt_pkg::coord_t                 rz;
  logic [ppt_pkg::COORD_W-1:0]     kmag;
  logic                            kneg;
  logic [1:0]                      rot_q;
  ppt_pkg::coord_t                 rot_z;

  logic                            res_valid;
  ppt_pkg::coord_t                 res_cx, res_cy, res_vx, res_vy, res_fx, res_fy;
  logic [ppt_pkg::AREA_W-1:0]      res_area;

  logic                            cmd_ready;
  logic                            accept;
  ppt_pkg::func_t                  fn;

  logic [ppt_pkg::COORD_W-1:0]     mul_a, mul_b;
  ppt_pkg::prod_t                  mul_p;
  logic                            wb_en;
  ppt_pkg::coord_t                 wb_val;

  ppt_pkg::coord_t                 sel_pt, sel_ctr;
  ppt_pkg::diff_t                  diff, diff_neg;
  logic [ppt_pkg::COORD_W-1:0]     diff_mag;
  ppt_pkg::prod_t                  sc_rnd;
  ppt_pkg::sat_t                   sc_off;
  ppt_pkg::coord_t                 sc_val;
  ppt_pkg::rot_t                   ex, ey, qx, qy;
  ppt_pkg::rot_t                   xs, ys;
  ppt_pkg::rot_t                   uv, uv_neg;
  logic [ppt_pkg::ROT_W-1:0]       umag;
  logic                            uneg;
  ppt_pkg::prod_t                  uq, uq_rnd;
  ppt_pkg::sat_t                   rt_off;
  ppt_pkg::coord_t                 rt_val;
  logic [ppt_pkg::COORD_W-1:0]     ang;
  logic [1:0]                      ang_q;
  ppt_pkg::acc_t                   area_sh;
  logic [ppt_pkg::AREA_W-1:0]      area_val;

  assign accept = cmd.valid && cmd_ready;
  assign fn     = ppt_pkg::func_t'(cmd.func);

  assign cmd.ready        = cmd_ready;
  assign res.valid        = res_valid;
  assign res.center_x_out = res_cx;
  assign res.center_y_out = res_cy;
  assign res.vertex_x_out = res_vx;
  assign res.vertex_y_out = res_vy;
  assign res.focus_x_out  = res_fx;
  assign res.focus_y_out  = res_fy;
  assign res.square_area  = res_area;

  // Datapath.
  always_comb begin
    unique case ({(state == ppt_pkg::ST_AR_DIFF) ? 1'b0 : pt_sel, axis})
      2'b00:   sel_pt = vertex_x;
      2'b01:   sel_pt = vertex_y;
      2'b10:   sel_pt = focus_x;
      default: sel_pt = focus_y;
    endcase
    sel_ctr  = axis ? center_y : center_x;
    diff     = ppt_pkg::diff_t'(sel_pt) - ppt_pkg::diff_t'(sel_ctr);
    diff_neg = -diff;
    diff_mag = diff[ppt_pkg::DIFF_W-1] ? diff_neg[ppt_pkg::COORD_W-1:0]
                                       : diff[ppt_pkg::COORD_W-1:0];

    sc_rnd = (prod + (ppt_pkg::prod_t'(1) << (ppt_pkg::FRAC_BITS - 1)))
             >> ppt_pkg::FRAC_BITS;
    sc_off = (dneg ^ kneg) ? -ppt_pkg::sat_t'(sc_rnd) : ppt_pkg::sat_t'(sc_rnd);
    sc_val = ppt_pkg::sat_coord(ppt_pkg::sat_t'(sel_ctr) + sc_off);

    ex = ppt_pkg::rot_t'(pt_sel ? focus_x : vertex_x) - ppt_pkg::rot_t'(center_x);
    ey = ppt_pkg::rot_t'(pt_sel ? focus_y : vertex_y) - ppt_pkg::rot_t'(center_y);
    unique case (rot_q)
      2'd0:    begin qx = ex;  qy = ey;  end
      2'd1:    begin qx = -ey; qy = ex;  end
      2'd2:    begin qx = -ex; qy = -ey; end
      default: begin qx = ey;  qy = -ex; end
    endcase

    xs = rx >>> step;
    ys = ry >>> step;

    uv     = axis ? ry : rx;
    uv_neg = -uv;
    uneg   = uv[ppt_pkg::ROT_W-1];
    umag   = uneg ? uv_neg : uv;
    uq     = prod + acc[ppt_pkg::PROD_W-1:0];
    uq_rnd = (uq + (ppt_pkg::prod_t'(1) << (ppt_pkg::GUARD_BITS - 1)))
             >> ppt_pkg::GUARD_BITS;
    rt_off = uneg ? -ppt_pkg::sat_t'(uq_rnd) : ppt_pkg::sat_t'(uq_rnd);
    rt_val = ppt_pkg::sat_coord(ppt_pkg::sat_t'(sel_ctr) + rt_off);

    ang   = {cmd.turn_angle, {(ppt_pkg::COORD_W - ppt_pkg::ANGLE_W){1'b0}}};
    ang_q = ang[ppt_pkg::COORD_W-1 -: 2] + {1'b0, ang[ppt_pkg::COORD_W-3]};

    area_sh  = acc >> (ppt_pkg::FRAC_BITS - 1);
    area_val = (|area_sh[ppt_pkg::ACC_W-1:ppt_pkg::AREA_W]) ? '1
                                                            : area_sh[ppt_pkg::AREA_W-1:0];
  end

  assign mul_p = ppt_pkg::prod_t'(mul_a) * ppt_pkg::prod_t'(mul_b);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ppt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (fn)
            ppt_pkg::FN_SCALE:  state_next = ppt_pkg::ST_SC_DIFF;
            ppt_pkg::FN_ROTATE: state_next = ppt_pkg::ST_RT_LOAD;
            default:            state_next = ppt_pkg::ST_AR_DIFF;
          endcase
        end
      end
      ppt_pkg::ST_SC_DIFF: state_next = ppt_pkg::ST_SC_MUL;
      ppt_pkg::ST_SC_MUL:  state_next = ppt_pkg::ST_SC_WB;
      ppt_pkg::ST_SC_WB: begin
        state_next = (pt_sel && axis) ? ppt_pkg::ST_AR_DIFF : ppt_pkg::ST_SC_DIFF;
      end
      ppt_pkg::ST_RT_LOAD: state_next = ppt_pkg::ST_RT_ITER;
      ppt_pkg::ST_RT_ITER: begin
        if (step == ppt_pkg::STEP_W'(ppt_pkg::STEPS_EFF - 1)) begin
          state_next = ppt_pkg::ST_RT_MLO;
        end
      end
      ppt_pkg::ST_RT_MLO:  state_next = ppt_pkg::ST_RT_MHI;
      ppt_pkg::ST_RT_MHI:  state_next = ppt_pkg::ST_RT_WB;
      ppt_pkg::ST_RT_WB: begin
        if (!axis) begin
          state_next = ppt_pkg::ST_RT_MLO;
        end else if (!pt_sel) begin
          state_next = ppt_pkg::ST_RT_LOAD;
        end else begin
          state_next = ppt_pkg::ST_AR_DIFF;
        end
      end
      ppt_pkg::ST_AR_DIFF: state_next = ppt_pkg::ST_AR_MUL;
      ppt_pkg::ST_AR_MUL:  state_next = ppt_pkg::ST_AR_ACC;
      ppt_pkg::ST_AR_ACC:  state_next = axis ? ppt_pkg::ST_OUT : ppt_pkg::ST_AR_DIFF;
      ppt_pkg::ST_OUT: begin
        if (!res_valid || res.ready) begin
          state_next = ppt_pkg::ST_IDLE;
        end
      end
      default: state_next = ppt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cmd_ready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    wb_en     = 1'b0;
    wb_val    = sc_val;
    unique case (state)
      ppt_pkg::ST_IDLE:   cmd_ready = 1'b1;
      ppt_pkg::ST_SC_MUL: begin
        mul_a = dmag;
        mul_b = kmag;
      end
      ppt_pkg::ST_SC_WB:  wb_en = 1'b1;
      ppt_pkg::ST_RT_MLO: begin
        mul_a = umag[ppt_pkg::COORD_W-1:0];
        mul_b = ppt_pkg::INV_GAIN;
      end
      ppt_pkg::ST_RT_MHI: begin
        mul_a = ppt_pkg::COORD_W'(umag[ppt_pkg::ROT_W-1:ppt_pkg::COORD_W]);
        mul_b = ppt_pkg::INV_GAIN;
      end
      ppt_pkg::ST_RT_WB: begin
        wb_en  = 1'b1;
        wb_val = rt_val;
      end
      ppt_pkg::ST_AR_MUL: begin
        mul_a = dmag;
        mul_b = dmag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppt_pkg::ST_IDLE;
      res_valid <= 1'b0;
      pt_sel    <= 1'b0;
      axis      <= 1'b0;
      step      <= '0;
      center_x  <= '0;
      center_y  <= '0;
      vertex_x  <= '0;
      vertex_y  <= ppt_pkg::coord_t'(1) <<< ppt_pkg::FRAC_BITS;
      focus_x   <= '0;
      focus_y   <= '0;
    end else begin
      state <= state_next;

      if (accept) begin
        pt_sel <= 1'b0;
        axis   <= 1'b0;
        kneg   <= cmd.scale_factor[ppt_pkg::COORD_W-1];
        kmag   <= cmd.scale_factor[ppt_pkg::COORD_W-1] ? -cmd.scale_factor
                                                       : cmd.scale_factor;
        rot_q  <= ang_q;
        rot_z  <= ang - {ang_q, {(ppt_pkg::COORD_W - 2){1'b0}}};
        unique case (fn)
          ppt_pkg::FN_LOAD_CENTER: begin
            center_x <= cmd.coord_x;
            center_y <= cmd.coord_y;
          end
          ppt_pkg::FN_LOAD_VERTEX: begin
            vertex_x <= cmd.coord_x;
            vertex_y <= cmd.coord_y;
          end
          ppt_pkg::FN_LOAD_FOCUS: begin
            focus_x <= cmd.coord_x;
            focus_y <= cmd.coord_y;
          end
          ppt_pkg::FN_TRANSLATE: begin
            center_x <= ppt_pkg::sat_coord(ppt_pkg::sat_t'(center_x)
                                           + ppt_pkg::sat_t'(cmd.coord_x));
            center_y <= ppt_pkg::sat_coord(ppt_pkg::sat_t'(center_y)
                                           + ppt_pkg::sat_t'(cmd.coord_y));
            vertex_x <= ppt_pkg::sat_coord(ppt_pkg::sat_t'(vertex_x)
                                           + ppt_pkg::sat_t'(cmd.coord_x));
            vertex_y <= ppt_pkg::sat_coord(ppt_pkg::sat_t'(vertex_y)
                                           + ppt_pkg::sat_t'(cmd.coord_y));
            focus_x  <= ppt_pkg::sat_coord(ppt_pkg::sat_t'(focus_x)
                                           + ppt_pkg::sat_t'(cmd.coord_x));
            focus_y  <= ppt_pkg::sat_coord(ppt_pkg::sat_t'(focus_y)
                                           + ppt_pkg::sat_t'(cmd.coord_y));
          end
          default: ;
        endcase
      end else if (wb_en) begin
        unique case ({pt_sel, axis})
          2'b00:   vertex_x <= wb_val;
          2'b01:   vertex_y <= wb_val;
          2'b10:   focus_x  <= wb_val;
          default: focus_y  <= wb_val;
        endcase
      end

      unique case (state)
        ppt_pkg::ST_SC_DIFF, ppt_pkg::ST_AR_DIFF: begin
          dneg <= diff[ppt_pkg::DIFF_W-1];
          dmag <= diff_mag;
        end
        ppt_pkg::ST_SC_MUL, ppt_pkg::ST_RT_MLO, ppt_pkg::ST_AR_MUL: prod <= mul_p;
        ppt_pkg::ST_SC_WB:  {pt_sel, axis} <= {pt_sel, axis} + 2'd1;
        ppt_pkg::ST_RT_LOAD: begin
          rx   <= qx <<< ppt_pkg::GUARD_BITS;
          ry   <= qy <<< ppt_pkg::GUARD_BITS;
          rz   <= rot_z;
          step <= '0;
        end
        ppt_pkg::ST_RT_ITER: begin
          if (!rz[ppt_pkg::COORD_W-1]) begin
            rx <= rx - ys;
            ry <= ry + xs;
            rz <= rz - ppt_pkg::coord_t'(ppt_pkg::atan_entry(step));
          end else begin
            rx <= rx + ys;
            ry <= ry - xs;
            rz <= rz + ppt_pkg::coord_t'(ppt_pkg::atan_entry(step));
          end
          step <= step + 1'b1;
        end
        ppt_pkg::ST_RT_MHI: begin
          acc  <= ppt_pkg::acc_t'(prod >> ppt_pkg::COORD_W);
          prod <= mul_p;
        end
        ppt_pkg::ST_RT_WB: begin
          if (!axis) begin
            axis <= 1'b1;
          end else begin
            axis   <= 1'b0;
            pt_sel <= ~pt_sel;
          end
        end
        ppt_pkg::ST_AR_ACC: begin
          acc  <= axis ? acc + ppt_pkg::acc_t'(prod) : ppt_pkg::acc_t'(prod);
          axis <= ~axis;
        end
        default: ;
      endcase

      if (state == ppt_pkg::ST_OUT && (!res_valid || res.ready)) begin
        res_valid <= 1'b1;
        res_cx    <= center_x;
        res_cy    <= center_y;
        res_vx    <= vertex_x;
        res_vy    <= vertex_y;
        res_fx    <= focus_x;
        res_fy    <= focus_y;
        res_area  <= area_val;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_res_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == ppt_pkg::ST_OUT))
    else $error("result raised outside the output state");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("ready again right after a command transfer");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ppt_pkg::ST_RT_ITER) |-> (step < ppt_pkg::STEP_W'(ppt_pkg::STEPS_EFF)))
    else $error("CORDIC step counter out of range");

  a_center_stable: assert property (@(posedge clk) disable iff (rst)
    !(cmd.valid && cmd.ready) |=> ($stable(center_x) && $stable(center_y)))
    else $error("center changed without a command transfer");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for planar_point_transform
// Drives commands over the valid/ready command channel with random gaps and
// back-pressure on the result channel. A bit-exact model of the point
// transform predicts every result, and each result transfer is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int              FRAC          = ppt_pkg::FRAC_BITS;
  localparam int              GUARD         = ppt_pkg::GUARD_BITS;
  localparam int              ITERATIONS    = ppt_pkg::STEPS_EFF;
  localparam logic [63:0]     GAIN_INV      = 64'h0000_0000_9B74_EDA8;
  localparam logic [63:0]     AREA_FULL     = 64'h0000_FFFF_FFFF_FFFF;
  localparam ppt_pkg::coord_t COORD_MAX     = 32'sh7FFF_FFFF;
  localparam ppt_pkg::coord_t COORD_MIN     = 32'sh8000_0000;
  localparam ppt_pkg::coord_t ONE           = 32'sh0001_0000;
  localparam logic [ppt_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [ppt_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd7;
  localparam int              STUCK_LIMIT   = 2000;
  localparam int              SETTLE_CYCLES = 80;

  typedef struct packed {
    ppt_pkg::coord_t            cx;
    ppt_pkg::coord_t            cy;
    ppt_pkg::coord_t            vx;
    ppt_pkg::coord_t            vy;
    ppt_pkg::coord_t            fx;
    ppt_pkg::coord_t            fy;
    logic [ppt_pkg::AREA_W-1:0] area;
  } snapshot_t;

  logic clk;
  logic rst;

  ppt_cmd_if cmd_ch ();
  ppt_res_if res_ch ();

  planar_point_transform dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  ppt_pkg::coord_t ctr_x, ctr_y, vtx_x, vtx_y, foc_x, foc_y;
  snapshot_t       pending_snapshots[$];
  int              errors = 0;
  int              stuck_cycles = 0;
  int unsigned     gap_pct = 0;
  int unsigned     stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ppt_pkg::coord_t clamp32(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return ppt_pkg::coord_t'(v);
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint atan_step(input int i);
    longint r;
    case (i)
      0:       r = 'h20000000;
      1:       r = 'h12E4051D;
      2:       r = 'h09FB385B;
      3:       r = 'h051111D4;
      4:       r = 'h028B0D43;
      5:       r = 'h0145D7E1;
      6:       r = 'h00A2F61E;
      7:       r = 'h00517C55;
      8:       r = 'h0028BE53;
      9:       r = 'h00145F2E;
      10:      r = 'h000A2F98;
      11:      r = 'h000517CC;
      12:      r = 'h00028BE6;
      13:      r = 'h000145F3;
      14:      r = 'h0000A2F9;
      15:      r = 'h0000517C;
      16:      r = 'h000028BE;
      17:      r = 'h0000145F;
      18:      r = 'h00000A2F;
      19:      r = 'h00000517;
      20:      r = 'h0000028B;
      21:      r = 'h00000145;
      22:      r = 'h000000A2;
      23:      r = 'h00000051;
      default: r = 0;
    endcase
    return r;
  endfunction

  function automatic ppt_pkg::coord_t scale_axis(input ppt_pkg::coord_t p,
                                                 input ppt_pkg::coord_t c,
                                                 input ppt_pkg::coord_t k);
    longint      d;
    longint      s;
    logic [63:0] m;
    d = longint'(p) - longint'(c);
    m = magnitude(d) * magnitude(longint'(k));
    m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    s = ((d < 0) != (k < 0)) ? -longint'(m) : longint'(m);
    return clamp32(longint'(c) + s);
  endfunction

  // The CORDIC gain and the guard bits come off in one rounded step.
  function automatic longint remove_gain(input longint v);
    logic [63:0] m, hi, lo, t, q;
    m = magnitude(v);
    hi = m >> 32;
    lo = m & 64'h0000_0000_FFFF_FFFF;
    t = lo * GAIN_INV;
    q = hi * GAIN_INV + (t >> 32);
    q = (q + (64'd1 << (GUARD - 1))) >> GUARD;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void rotate_about_center(inout ppt_pkg::coord_t px,
                                              inout ppt_pkg::coord_t py,
                                              input logic [ppt_pkg::ANGLE_W-1:0] turn);
    logic [31:0] ang, biased, rest;
    logic [1:0]  quad;
    longint      ox, oy, xs, ys, swap, phase;
    int          i;
    ang    = {turn, 16'h0000};
    biased = ang + 32'h2000_0000;
    quad   = biased[31:30];
    rest   = ang - {quad, 30'd0};
    phase  = longint'($signed(rest));
    ox = longint'(px) - longint'(ctr_x);
    oy = longint'(py) - longint'(ctr_y);
    for (i = 0; i < quad; i++) begin
      swap = ox;
      ox = -oy;
      oy = swap;
    end
    ox = ox <<< GUARD;
    oy = oy <<< GUARD;
    for (i = 0; i < ITERATIONS; i++) begin
      xs = ox >>> i;
      ys = oy >>> i;
      if (phase >= 0) begin
        ox = ox - ys;
        oy = oy + xs;
        phase = phase - atan_step(i);
      end else begin
        ox = ox + ys;
        oy = oy - xs;
        phase = phase + atan_step(i);
      end
    end
    px = clamp32(longint'(ctr_x) + remove_gain(ox));
    py = clamp32(longint'(ctr_y) + remove_gain(oy));
  endfunction

  function automatic logic [ppt_pkg::AREA_W-1:0] vertex_area();
    logic [63:0] ax, ay, a, b, lowmask, sum;
    ax = magnitude(longint'(vtx_x) - longint'(ctr_x));
    ay = magnitude(longint'(vtx_y) - longint'(ctr_y));
    a = ax * ax;
    b = ay * ay;
    lowmask = (64'd1 << (FRAC - 1)) - 64'd1;
    sum = (a >> (FRAC - 1)) + (b >> (FRAC - 1))
        + (((a & lowmask) + (b & lowmask)) >> (FRAC - 1));
    if (sum > AREA_FULL) sum = AREA_FULL;
    return sum[ppt_pkg::AREA_W-1:0];
  endfunction

  function automatic snapshot_t transform_points(input logic [ppt_pkg::FUNC_W-1:0] fn,
                                                 input ppt_pkg::coord_t x,
                                                 input ppt_pkg::coord_t y,
                                                 input ppt_pkg::coord_t k,
                                                 input logic [ppt_pkg::ANGLE_W-1:0] turn);
    snapshot_t s;
    case (fn)
      ppt_pkg::FN_LOAD_CENTER: begin
        ctr_x = x;
        ctr_y = y;
      end
      ppt_pkg::FN_LOAD_VERTEX: begin
        vtx_x = x;
        vtx_y = y;
      end
      ppt_pkg::FN_LOAD_FOCUS: begin
        foc_x = x;
        foc_y = y;
      end
      ppt_pkg::FN_TRANSLATE: begin
        ctr_x = clamp32(longint'(ctr_x) + longint'(x));
        ctr_y = clamp32(longint'(ctr_y) + longint'(y));
        vtx_x = clamp32(longint'(vtx_x) + longint'(x));
        vtx_y = clamp32(longint'(vtx_y) + longint'(y));
        foc_x = clamp32(longint'(foc_x) + longint'(x));
        foc_y = clamp32(longint'(foc_y) + longint'(y));
      end
      ppt_pkg::FN_SCALE: begin
        vtx_x = scale_axis(vtx_x, ctr_x, k);
        vtx_y = scale_axis(vtx_y, ctr_y, k);
        foc_x = scale_axis(foc_x, ctr_x, k);
        foc_y = scale_axis(foc_y, ctr_y, k);
      end
      ppt_pkg::FN_ROTATE: begin
        rotate_about_center(vtx_x, vtx_y, turn);
        rotate_about_center(foc_x, foc_y, turn);
      end
      default: begin
      end
    endcase
    s.cx = ctr_x;
    s.cy = ctr_y;
    s.vx = vtx_x;
    s.vy = vtx_y;
    s.fx = foc_x;
    s.fy = foc_y;
    s.area = vertex_area();
    return s;
  endfunction

  function automatic int unsigned pick_idle(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic ppt_pkg::coord_t rand_coord();
    case ($urandom_range(9))
      0:       return ppt_pkg::coord_t'($urandom);
      1:       return $urandom_range(1) ? COORD_MAX : COORD_MIN;
      default: return ppt_pkg::coord_t'(int'($urandom_range(32'h0040_0000))
                                        - 32'sh0020_0000);
    endcase
  endfunction

  function automatic ppt_pkg::coord_t rand_factor();
    case ($urandom_range(9))
      0:       return ppt_pkg::coord_t'($urandom);
      1:       return $urandom_range(1) ? ONE : -ONE;
      2:       return '0;
      default: return ppt_pkg::coord_t'(int'($urandom_range(32'h0006_0000))
                                        - 32'sh0003_0000);
    endcase
  endfunction

  function automatic void compare_field(input string label, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
    end
  endfunction

  function automatic void check_result();
    snapshot_t want;
    if (pending_snapshots.size() == 0) begin
      errors++;
      $display("%0t: result transfer with nothing expected, expected none, actual %h",
               $time, res_ch.square_area);
      return;
    end
    want = pending_snapshots.pop_front();
    compare_field("center_x", want.cx, res_ch.center_x_out);
    compare_field("center_y", want.cy, res_ch.center_y_out);
    compare_field("vertex_x", want.vx, res_ch.vertex_x_out);
    compare_field("vertex_y", want.vy, res_ch.vertex_y_out);
    compare_field("focus_x", want.fx, res_ch.focus_x_out);
    compare_field("focus_y", want.fy, res_ch.focus_y_out);
    compare_field("square_area", want.area, res_ch.square_area);
  endfunction

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      check_result();
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned hold;
    hold = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        hold = pick_idle(stall_pct);
        res_ch.ready <= (hold == 0);
      end
    end
  end

  task automatic send_cmd(input logic [ppt_pkg::FUNC_W-1:0] fn, input ppt_pkg::coord_t x,
                          input ppt_pkg::coord_t y, input ppt_pkg::coord_t k,
                          input logic [ppt_pkg::ANGLE_W-1:0] turn);
    int unsigned idle_len;
    idle_len = pick_idle(gap_pct);
    @(negedge clk);
    if (idle_len > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (idle_len) @(negedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.func         <= fn;
    cmd_ch.coord_x      <= x;
    cmd_ch.coord_y      <= y;
    cmd_ch.scale_factor <= k;
    cmd_ch.turn_angle   <= turn;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_snapshots.push_back(transform_points(fn, x, y, k, turn));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    logic [ppt_pkg::FUNC_W-1:0] fn;
    int unsigned                pick;
    pick = $urandom_range(99);
    if (pick < 12) fn = ppt_pkg::FN_LOAD_CENTER;
    else if (pick < 24) fn = ppt_pkg::FN_LOAD_VERTEX;
    else if (pick < 36) fn = ppt_pkg::FN_LOAD_FOCUS;
    else if (pick < 50) fn = ppt_pkg::FN_TRANSLATE;
    else if (pick < 68) fn = ppt_pkg::FN_SCALE;
    else if (pick < 95) fn = ppt_pkg::FN_ROTATE;
    else fn = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
    send_cmd(fn, rand_coord(), rand_coord(), rand_factor(), 16'($urandom));
  endtask

  task automatic test_idle_codes();
    send_cmd(FN_SPARE_A, COORD_MAX, COORD_MIN, COORD_MAX, 16'hFFFF);
    send_cmd(FN_SPARE_B, COORD_MIN, COORD_MAX, COORD_MIN, 16'h0000);
  endtask

  task automatic test_loads();
    send_cmd(ppt_pkg::FN_LOAD_CENTER, COORD_MIN, COORD_MIN, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_LOAD_VERTEX, COORD_MAX, COORD_MAX, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_LOAD_FOCUS, COORD_MAX, COORD_MIN, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_LOAD_CENTER, '0, '0, '0, 16'h0000);
  endtask

  task automatic test_translate();
    send_cmd(ppt_pkg::FN_TRANSLATE, COORD_MAX, COORD_MAX, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_TRANSLATE, COORD_MIN, COORD_MIN, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_LOAD_CENTER, ONE, -ONE, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_LOAD_VERTEX, 3 * ONE, ONE, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_LOAD_FOCUS, -ONE, 2 * ONE, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_TRANSLATE, -32'sh0000_8000, 32'sh0001_8000, '0, 16'h0000);
  endtask

  task automatic test_scale();
    send_cmd(ppt_pkg::FN_LOAD_CENTER, ONE, -ONE, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_SCALE, '0, '0, ONE, 16'h0000);
    send_cmd(ppt_pkg::FN_SCALE, '0, '0, -ONE, 16'h0000);
    send_cmd(ppt_pkg::FN_LOAD_VERTEX, ONE + 3, -ONE + 1, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_SCALE, '0, '0, 32'sh0000_8000, 16'h0000);
    send_cmd(ppt_pkg::FN_SCALE, '0, '0, COORD_MAX, 16'h0000);
    send_cmd(ppt_pkg::FN_SCALE, '0, '0, COORD_MIN, 16'h0000);
    send_cmd(ppt_pkg::FN_SCALE, '0, '0, '0, 16'h0000);
  endtask

  task automatic test_rotate();
    send_cmd(ppt_pkg::FN_LOAD_VERTEX, 3 * ONE, -ONE, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_LOAD_FOCUS, -5 * ONE, 7 * ONE, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_ROTATE, '0, '0, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_ROTATE, '0, '0, '0, 16'h4000);
    send_cmd(ppt_pkg::FN_ROTATE, '0, '0, '0, 16'hC000);
    send_cmd(ppt_pkg::FN_ROTATE, '0, '0, '0, 16'h2000);
    send_cmd(ppt_pkg::FN_ROTATE, '0, '0, '0, 16'h6000);
    send_cmd(ppt_pkg::FN_ROTATE, '0, '0, '0, 16'hFFFF);
    send_cmd(ppt_pkg::FN_LOAD_VERTEX, ONE, -ONE, '0, 16'h0000);
    send_cmd(ppt_pkg::FN_ROTATE, '0, '0, '0, 16'h1234);
  endtask

  task automatic test_random_streaming(input int n);
    gap_pct = 0;
    stall_pct = 0;
    repeat (n) random_item();
  endtask

  task automatic test_random_backpressure(input int n);
    gap_pct = 0;
    stall_pct = 70;
    repeat (n) random_item();
  endtask

  task automatic test_random_sparse(input int n);
    gap_pct = 60;
    stall_pct = 10;
    repeat (n) random_item();
  endtask

  task automatic test_random_mixed(input int n);
    gap_pct = 30;
    stall_pct = 30;
    repeat (n) random_item();
  endtask

  initial begin
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.func         = '0;
    cmd_ch.coord_x      = '0;
    cmd_ch.coord_y      = '0;
    cmd_ch.scale_factor = '0;
    cmd_ch.turn_angle   = '0;
    ctr_x = '0;
    ctr_y = '0;
    vtx_x = '0;
    vtx_y = ONE;
    foc_x = '0;
    foc_y = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_pct = 20;
    stall_pct = 20;
    test_idle_codes();
    test_loads();
    test_translate();
    test_scale();
    test_rotate();
    wait_drained();

    test_random_streaming(400);
    wait_drained();
    test_random_backpressure(400);
    test_random_sparse(300);
    wait_drained();
    test_random_mixed(800);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: planar_point_transform.f
src/ppt_pkg.sv
src/ppt_if.sv
src/planar_point_transform.sv
verif/testbench.sv
